FILE: src/bole_pkg.sv
package bole_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_ORDERED = 3'd0,
        REQ_HEAD    = 3'd1,
        REQ_REMOVE  = 3'd2,
        REQ_SEARCH  = 3'd3,
        REQ_INCR    = 3'd4
    } t_req_code;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         position;
        logic signed [31:0] removed_value;
        logic [4:0]         entry_count;
    } t_rsp;

    // per-node update
    typedef enum logic [1:0] {
        NODE_HOLD = 2'd0,
        NODE_INS  = 2'd1,
        NODE_DEL  = 2'd2,
        NODE_INC  = 2'd3
    } t_node_op;

    typedef struct packed {
        t_node_op op;
        logic     cmp_en;
    } t_node_cmd;

endpackage

FILE: src/bounded_ordered_list_engine.sv
// Flow: remove head, insert at head, increment all and rejected items go from acceptance
//   straight to S_APPLY; ordered insert and search pass S_CMP and S_SCAN first, the scan
//   stopping at the first match or at the element count; S_APPLY waits for a free output.
// Throughput: one item in flight; the position scan steps one slot per cycle.
// Reset: synchronous, active low; clears the element count and the handshake state.
//   Stored element values are left as they are; no clearing pass is run.
module bounded_ordered_list_engine #(
    parameter int LIST_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  bole_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output bole_pkg::t_rsp o_rsp
);

    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;  // slot index
    localparam int CW = $clog2(LIST_DEPTH + 1);                     // count
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    // S_CMP latches every node's compare flags, S_SCAN walks them from the head
    // for the first hit, S_APPLY updates the whole row at once and loads the
    // result register when the output is free.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state             r_state;
    logic [2:0]         r_req_type;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_idx;
    logic [PW-1:0]      r_pos;
    logic [1:0]         r_status;
    bole_pkg::t_node_op r_op;
    logic [CW-1:0]      r_count;
    logic               r_rsp_valid;
    bole_pkg::t_rsp     r_rsp;

    logic signed [31:0]  w_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_le;
    logic [LIST_DEPTH-1:0] w_eq;
    bole_pkg::t_node_cmd w_cmd;
    logic                w_out_free;
    logic                w_load;
    logic                w_hit;
    logic                w_full;
    logic                w_empty;
    logic [CW-1:0]       w_count_next;

    assign w_out_free = !r_rsp_valid || i_rsp_ready;
    assign w_load     = (r_state == S_APPLY) && w_out_free;
    assign w_full     = (r_count == DEPTH_C);
    assign w_empty    = (r_count == '0);

    // first-hit test at the scan pointer: less-or-equal for ordered insert,
    // equality for search
    assign w_hit = (r_req_type == bole_pkg::REQ_ORDERED) ? w_le[r_idx[PW-1:0]]
                                                         : w_eq[r_idx[PW-1:0]];

    always_comb begin
        w_cmd.cmp_en = (r_state == S_CMP);
        w_cmd.op     = w_load ? r_op : bole_pkg::NODE_HOLD;
    end

    always_comb begin
        case (r_op)
            bole_pkg::NODE_INS: w_count_next = r_count + CW'(1);
            bole_pkg::NODE_DEL: w_count_next = r_count - CW'(1);
            default:            w_count_next = r_count;
        endcase
    end

    // the row: each node shifts from its left neighbor on insert and from its
    // right neighbor on remove
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_row
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = r_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        bole_node #(
            .IDX_W (PW),
            .INDEX (g)
        ) u_node (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (r_pos),
            .i_value (r_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_le    (w_le[g]),
            .o_eq    (w_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
            r_op        <= bole_pkg::NODE_HOLD;
        end else begin
            if (r_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req_type <= i_req.req_type;
                        r_value    <= i_req.value;
                        r_idx      <= '0;
                        r_pos      <= '0;
                        r_status   <= bole_pkg::STATUS_OK;
                        r_op       <= bole_pkg::NODE_HOLD;
                        r_state    <= S_APPLY;
                        case (i_req.req_type)
                            bole_pkg::REQ_ORDERED: begin
                                if (w_full) begin
                                    r_status <= bole_pkg::STATUS_FULL;
                                end else begin
                                    r_op    <= bole_pkg::NODE_INS;
                                    r_state <= S_CMP;
                                end
                            end
                            bole_pkg::REQ_HEAD: begin
                                if (w_full) begin
                                    r_status <= bole_pkg::STATUS_FULL;
                                end else begin
                                    r_op <= bole_pkg::NODE_INS;
                                end
                            end
                            bole_pkg::REQ_REMOVE: begin
                                if (w_empty) begin
                                    r_status <= bole_pkg::STATUS_EMPTY;
                                end else begin
                                    r_op <= bole_pkg::NODE_DEL;
                                end
                            end
                            bole_pkg::REQ_SEARCH: begin
                                r_state <= S_CMP;
                            end
                            bole_pkg::REQ_INCR: begin
                                r_op <= bole_pkg::NODE_INC;
                            end
                            default: begin
                                // unused codes: no operation
                            end
                        endcase
                    end
                end
                S_CMP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx >= r_count) begin
                        // no hit: ordered insert goes to the tail
                        if (r_req_type == bole_pkg::REQ_ORDERED) begin
                            r_pos <= r_count[PW-1:0];
                        end else begin
                            r_status <= bole_pkg::STATUS_NOTFOUND;
                        end
                        r_state <= S_APPLY;
                    end else if (w_hit) begin
                        r_pos   <= r_idx[PW-1:0];
                        r_state <= S_APPLY;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_APPLY: begin
                    if (w_out_free) begin
                        r_count                <= w_count_next;
                        r_rsp_valid            <= 1'b1;
                        r_rsp.status           <= r_status;
                        r_rsp.position         <= 4'(r_pos);
                        r_rsp.removed_value    <= (r_op == bole_pkg::NODE_DEL) ? w_data[0]
                                                                               : 32'sd0;
                        r_rsp.entry_count      <= 5'(w_count_next);
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // count stays within the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("element count beyond depth");

    // no insert issued into a full row
    a_no_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == bole_pkg::NODE_INS) |-> (r_count < DEPTH_C))
        else $error("insert into full row");

    // scan pointer never passes the count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan pointer past count");

    // reported count matches the count held after the update
    a_count_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_rsp.entry_count == 5'(r_count)))
        else $error("reported count mismatch");

endmodule

FILE: src/bole_node.sv
// One list slot: holds an element, compares it against the broadcast value,
// and on command takes the left neighbor, the right neighbor, the new value,
// or its own value plus one (held at the maximum value).
module bole_node #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  bole_pkg::t_node_cmd   i_cmd,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic signed [31:0]    i_value,
    input  logic signed [31:0]    i_left,
    input  logic signed [31:0]    i_right,
    output logic signed [31:0]    o_data,
    output logic                  o_le,
    output logic                  o_eq
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [31:0] r_data;
    logic               r_le;
    logic               r_eq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_le <= (i_value <= r_data);
            r_eq <= (i_value == r_data);
        end
        case (i_cmd.op)
            bole_pkg::NODE_INS: begin
                if (MY_IDX == i_pos) begin
                    r_data <= i_value;
                end else if (MY_IDX > i_pos) begin
                    r_data <= i_left;
                end
            end
            bole_pkg::NODE_DEL: begin
                r_data <= i_right;
            end
            bole_pkg::NODE_INC: begin
                if (r_data != bole_pkg::VALUE_MAX) begin
                    r_data <= r_data + 32'sd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_le   = r_le;
    assign o_eq   = r_eq;

endmodule
